### rtl/ftu_pkg.sv
// Shared types and constants for the fermentation thermostat unit.
// No dependencies; the unit's modules and the bench import this package.
`default_nettype none

package ftu_pkg;

  // Phase codes as reported on the result channel
  typedef enum logic [2:0] {
    PH_NONE = 3'd0,
    PH_HEAT = 3'd1,
    PH_COOL = 3'd2,
    PH_FERM = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_FLAGS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF_SEC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_SEC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_HRS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STIR_SPEED    = 3'd7;

  // enable_flags bit positions
  localparam int unsigned FLAG_COOL      = 0;
  localparam int unsigned FLAG_HEAT      = 1;
  localparam int unsigned FLAG_STIR      = 2;
  localparam int unsigned FLAG_LEVEL     = 3;
  localparam int unsigned FLAG_TRIG_ABOVE = 4;

  // Reset values
  localparam logic signed [14:0] TARGET_TEMP_RST = 15'sd2200;
  localparam logic [10:0]        BAND_HALF_RST   = 11'd50;

  // Fixed behavior constants
  localparam logic signed [16:0] STIR_SAFE_TEMP = 17'sd6000;
  localparam logic [6:0]         HEAT_POWER     = 7'd10;
  localparam logic [9:0]         MS_PER_SEC     = 10'd1000;
  localparam logic [21:0]        MS_PER_HOUR    = 22'd3600000;

  typedef struct packed {
    logic signed [14:0] target_temp;
    logic [10:0]        band_half_width;
    logic [4:0]         enable_flags;
    logic [12:0]        level_threshold_mv;
    logic [15:0]        min_off_seconds;
    logic [15:0]        min_on_seconds;
    logic [9:0]         duration_hours;
    logic [6:0]         stir_speed_pct;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    target_temp:        TARGET_TEMP_RST,
    band_half_width:    BAND_HALF_RST,
    enable_flags:       5'd0,
    level_threshold_mv: 13'd0,
    min_off_seconds:    16'd0,
    min_on_seconds:     16'd0,
    duration_hours:     10'd0,
    stir_speed_pct:     7'd0
  };

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               temp_valid;
    logic signed [14:0] temp_centi;
    logic [12:0]        level_mv;
  } in_item_t;

  typedef struct packed {
    logic [6:0] heater_power;
    logic       valve_open;
    logic       stir_start;
    logic [6:0] stir_speed;
    logic       foam_alarm;
    phase_t     phase;
    logic       phase_changed;
    logic       done_res;
  } res_t;

endpackage

`default_nettype wire

### rtl/ftu_in_if.sv
// Input channel of the fermentation thermostat unit: valid/ready plus one tick.
// No dependencies.
`default_nettype none

interface ftu_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               temp_valid;
  logic signed [14:0] temp_centi;
  logic [12:0]        level_mv;

  modport source (output valid, now_ms, temp_valid, temp_centi, level_mv, input ready);
  modport sink   (input valid, now_ms, temp_valid, temp_centi, level_mv, output ready);
endinterface

`default_nettype wire

### rtl/ftu_out_if.sv
// Result channel of the fermentation thermostat unit: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface ftu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] heater_power;
  logic       valve_open;
  logic       stir_start;
  logic [6:0] stir_speed;
  logic       foam_alarm;
  logic [2:0] phase;
  logic       phase_changed;
  logic       done_res;

  modport source (output valid, heater_power, valve_open, stir_start, stir_speed,
                  foam_alarm, phase, phase_changed, done_res, input ready);
  modport sink   (input valid, heater_power, valve_open, stir_start, stir_speed,
                  foam_alarm, phase, phase_changed, done_res, output ready);
endinterface

`default_nettype wire

### rtl/fermentation_thermostat_unit.sv
// Top level of the fermentation thermostat unit: input register, control step,
// result register. Depends on ftu_pkg, ftu_in_if, ftu_out_if, ftu_cfg, ftu_core.
`default_nettype none

// One transaction in, one result out. The unit takes a new tick every clock
// cycle unless the pipeline is held; each tick waits in the input register,
// then the control step writes its result into the result register. The
// result register is parted from the input register, so a waiting result
// does not stop the next tick from being taken; a stalled result holds the
// pipeline only once both registers are full. Configuration writes take
// effect on the next clock and are meant to be issued while no tick is in
// flight.
module fermentation_thermostat_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ftu_in_if.sink                              in_ch,
  ftu_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ftu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ftu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ftu_pkg::*;

  cfg_t     cfg;
  in_item_t in_item_r;
  logic     in_vld_r;
  res_t     res, out_res_r;
  logic     out_vld_r;
  logic     advance;
  logic     in_take;

  ftu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ftu_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) in_vld_r <= 1'b1;
      else if (advance) in_vld_r <= 1'b0;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= '{now_ms:     in_ch.now_ms,
                     temp_valid: in_ch.temp_valid,
                     temp_centi: in_ch.temp_centi,
                     level_mv:   in_ch.level_mv};
    end
    if (advance) out_res_r <= res;
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.heater_power  = out_res_r.heater_power;
  assign out_ch.valve_open    = out_res_r.valve_open;
  assign out_ch.stir_start    = out_res_r.stir_start;
  assign out_ch.stir_speed    = out_res_r.stir_speed;
  assign out_ch.foam_alarm    = out_res_r.foam_alarm;
  assign out_ch.phase         = out_res_r.phase;
  assign out_ch.phase_changed = out_res_r.phase_changed;
  assign out_ch.done_res      = out_res_r.done_res;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_ch.ready)
    else $error("input stalled with empty input register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed transaction did not reach result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |-> !advance)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/ftu_cfg.sv
// Configuration register file of the fermentation thermostat unit.
// Depends on ftu_pkg.
`default_nettype none

module ftu_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ftu_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ftu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ftu_pkg::cfg_t                         cfg
);
  import ftu_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TARGET_TEMP:  cfg_nxt.target_temp        = cfg_wdata[14:0];
        CFG_BAND_HALF:    cfg_nxt.band_half_width    = cfg_wdata[10:0];
        CFG_ENABLE_FLAGS: cfg_nxt.enable_flags       = cfg_wdata[4:0];
        CFG_LEVEL_THR:    cfg_nxt.level_threshold_mv = cfg_wdata[12:0];
        CFG_MIN_OFF_SEC:  cfg_nxt.min_off_seconds    = cfg_wdata[15:0];
        CFG_MIN_ON_SEC:   cfg_nxt.min_on_seconds     = cfg_wdata[15:0];
        CFG_DURATION_HRS: cfg_nxt.duration_hours     = cfg_wdata[9:0];
        CFG_STIR_SPEED:   cfg_nxt.stir_speed_pct     = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/ftu_core.sv
// Control step of the fermentation thermostat unit: phase, valve and timer state
// plus the combinational decision for one tick. Depends on ftu_pkg.
`default_nettype none

module ftu_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire ftu_pkg::in_item_t item,
  input  wire ftu_pkg::cfg_t     cfg,
  output ftu_pkg::res_t          res
);
  import ftu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] phase_start_r, phase_start_nxt;
  logic        cool_act_r, cool_act_nxt;
  logic [31:0] valve_chg_r, valve_chg_nxt;
  logic        valve_r, valve_nxt;

  logic               foam;
  phase_t             phase_sel;
  logic signed [16:0] temp_x, lo_x, hi_x;
  logic [31:0]        valve_el, phase_el;
  logic [25:0]        min_off_ms, min_on_ms;
  logic [31:0]        dur_ms;
  logic               active;

  // Foam detection, hysteresis band selection, activity flag and timer limits in ms
  always_comb begin
    temp_x = {{2{item.temp_centi[14]}}, item.temp_centi};
    lo_x   = {{2{cfg.target_temp[14]}}, cfg.target_temp} - $signed({6'd0, cfg.band_half_width});
    hi_x   = {{2{cfg.target_temp[14]}}, cfg.target_temp} + $signed({6'd0, cfg.band_half_width});

    foam = 1'b0;
    if (cfg.enable_flags[FLAG_LEVEL]) begin
      foam = cfg.enable_flags[FLAG_TRIG_ABOVE] ? (item.level_mv >= cfg.level_threshold_mv)
                                               : (item.level_mv <= cfg.level_threshold_mv);
    end

    if (temp_x < lo_x) phase_sel = PH_HEAT;
    else if (temp_x > hi_x && cfg.enable_flags[FLAG_COOL]) phase_sel = PH_COOL;
    else phase_sel = PH_FERM;

    active = (phase_r != PH_DONE) && item.temp_valid;

    min_off_ms = 26'(cfg.min_off_seconds) * 26'(MS_PER_SEC);
    min_on_ms  = 26'(cfg.min_on_seconds) * 26'(MS_PER_SEC);
    dur_ms     = 32'(cfg.duration_hours) * 32'(MS_PER_HOUR);
  end

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    cool_act_nxt    = cool_act_r;
    valve_chg_nxt   = valve_chg_r;
    valve_nxt       = valve_r;
    valve_el        = item.now_ms - valve_chg_r;
    phase_el        = '0;

    if (phase_r == PH_DONE) begin
      // terminal until reset
    end else if (!item.temp_valid) begin
      valve_nxt = 1'b0;
    end else if (foam) begin
      if (cfg.enable_flags[FLAG_COOL]) valve_nxt = 1'b1;
    end else begin
      if (phase_sel != phase_r) begin
        phase_nxt       = phase_sel;
        phase_start_nxt = item.now_ms;
      end
      phase_el = item.now_ms - phase_start_nxt;
      case (phase_sel)
        PH_HEAT: begin
          valve_nxt    = 1'b0;
          cool_act_nxt = 1'b0;
        end
        PH_COOL: begin
          if (!cool_act_r || valve_el >= {6'd0, min_off_ms}) begin
            valve_nxt     = 1'b1;
            cool_act_nxt  = 1'b1;
            valve_chg_nxt = item.now_ms;
          end
        end
        default: begin
          if (cool_act_r && valve_el >= {6'd0, min_on_ms}) begin
            valve_nxt     = 1'b0;
            cool_act_nxt  = 1'b0;
            valve_chg_nxt = item.now_ms;
          end
          if (cfg.duration_hours != '0 && phase_el >= dur_ms) phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  // Result of this tick
  always_comb begin
    res = '0;
    res.heater_power  = (active && !foam && phase_sel == PH_HEAT &&
                         cfg.enable_flags[FLAG_HEAT]) ? HEAT_POWER : 7'd0;
    res.valve_open    = valve_nxt;
    res.stir_start    = active && foam && cfg.enable_flags[FLAG_STIR] &&
                        (temp_x <= STIR_SAFE_TEMP);
    res.stir_speed    = res.stir_start ? cfg.stir_speed_pct : 7'd0;
    res.foam_alarm    = active && foam;
    res.phase         = phase_nxt;
    res.phase_changed = phase_nxt != phase_r;
    res.done_res      = phase_nxt == PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_NONE;
      phase_start_r <= '0;
      cool_act_r    <= 1'b0;
      valve_chg_r   <= '0;
      valve_r       <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      cool_act_r    <= cool_act_nxt;
      valve_chg_r   <= valve_chg_nxt;
      valve_r       <= valve_nxt;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("completed phase left without reset");

  a_invalid_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r != PH_DONE && !item.temp_valid |=> !valve_r)
    else $error("valve open after invalid temperature");

  a_heat_only_heating: assert property (@(posedge clk) disable iff (!rst_n)
    res.heater_power != 7'd0 |-> res.phase == PH_HEAT && !res.valve_open)
    else $error("heater on outside heating phase");

  // cooling only ever starts by opening the valve
  a_cool_valve: assert property (@(posedge clk) disable iff (!rst_n)
    step && cool_act_nxt && !cool_act_r |=> valve_r)
    else $error("cooling started with valve closed");

endmodule

`default_nettype wire

### bench/ftu_result_checker.sv
// Result checker for the fermentation thermostat unit: watches both channels and the
// register port, predicts each result and compares it field by field. Needs ftu_pkg,
// ftu_in_if and ftu_out_if.
`default_nettype none

module ftu_result_checker
  import ftu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ftu_in_if                         in_mon,
  ftu_out_if                        out_mon,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        outstanding
);

  cfg_t        regs;
  phase_t      cur_phase;
  logic [31:0] phase_start;
  logic [31:0] valve_stamp;
  logic        cooling_on;
  logic        valve_on;
  res_t        pending_q[$];
  int          result_no;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    result_no   = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, result_no, msg);
  endtask

  function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TARGET_TEMP:  regs.target_temp        = data[14:0];
      CFG_BAND_HALF:    regs.band_half_width    = data[10:0];
      CFG_ENABLE_FLAGS: regs.enable_flags       = data[4:0];
      CFG_LEVEL_THR:    regs.level_threshold_mv = data[12:0];
      CFG_MIN_OFF_SEC:  regs.min_off_seconds    = data;
      CFG_MIN_ON_SEC:   regs.min_on_seconds     = data;
      CFG_DURATION_HRS: regs.duration_hours     = data[9:0];
      CFG_STIR_SPEED:   regs.stir_speed_pct     = data[6:0];
      default: ;
    endcase
  endfunction

  // One control step: updates the thermostat state and returns the result it reports.
  function automatic res_t thermostat_step(input in_item_t t);
    res_t        r;
    phase_t      entry_phase;
    phase_t      next_phase;
    int          temp;
    int          tgt;
    int          band;
    logic        foam;
    logic [31:0] since_valve;
    logic [31:0] since_phase;
    r           = '0;
    entry_phase = cur_phase;
    temp        = $signed(t.temp_centi);
    tgt         = $signed(regs.target_temp);
    band        = regs.band_half_width;
    if (cur_phase == PH_DONE) begin
      // terminal, inputs are ignored
    end else if (!t.temp_valid) begin
      valve_on = 1'b0;
    end else begin
      foam = 1'b0;
      if (regs.enable_flags[FLAG_LEVEL])
        foam = regs.enable_flags[FLAG_TRIG_ABOVE] ? (t.level_mv >= regs.level_threshold_mv)
                                                  : (t.level_mv <= regs.level_threshold_mv);
      if (foam) begin
        r.foam_alarm = 1'b1;
        if (regs.enable_flags[FLAG_COOL]) valve_on = 1'b1;
        if (regs.enable_flags[FLAG_STIR] && temp <= STIR_SAFE_TEMP) r.stir_start = 1'b1;
      end else begin
        if (temp < tgt - band) next_phase = PH_HEAT;
        else if (temp > tgt + band && regs.enable_flags[FLAG_COOL]) next_phase = PH_COOL;
        else next_phase = PH_FERM;
        if (next_phase != cur_phase) begin
          cur_phase   = next_phase;
          phase_start = t.now_ms;
        end
        since_valve = t.now_ms - valve_stamp;
        since_phase = t.now_ms - phase_start;
        if (cur_phase == PH_HEAT) begin
          valve_on       = 1'b0;
          cooling_on     = 1'b0;
          r.heater_power = regs.enable_flags[FLAG_HEAT] ? HEAT_POWER : 7'd0;
        end else if (cur_phase == PH_COOL) begin
          // open the valve at once if cooling is off, else refresh it once the interval has run out
          if (!cooling_on || {32'd0, since_valve} >= regs.min_off_seconds * 64'd1000) begin
            valve_on    = 1'b1;
            cooling_on  = 1'b1;
            valve_stamp = t.now_ms;
          end
        end else begin
          if (cooling_on && {32'd0, since_valve} >= regs.min_on_seconds * 64'd1000) begin
            valve_on    = 1'b0;
            cooling_on  = 1'b0;
            valve_stamp = t.now_ms;
          end
          if (regs.duration_hours != 0 &&
              {32'd0, since_phase} >= regs.duration_hours * 64'd3600000)
            cur_phase = PH_DONE;
        end
      end
    end
    r.valve_open    = valve_on;
    r.stir_speed    = r.stir_start ? regs.stir_speed_pct : 7'd0;
    r.phase         = cur_phase;
    r.phase_changed = (cur_phase != entry_phase);
    r.done_res      = (cur_phase == PH_DONE);
    return r;
  endfunction

  task automatic compare_result(input res_t want);
    if (out_mon.heater_power !== want.heater_power)
      report_mismatch($sformatf("heater_power %0d, expected %0d",
                                out_mon.heater_power, want.heater_power));
    if (out_mon.valve_open !== want.valve_open)
      report_mismatch($sformatf("valve_open %0b, expected %0b",
                                out_mon.valve_open, want.valve_open));
    if (out_mon.stir_start !== want.stir_start)
      report_mismatch($sformatf("stir_start %0b, expected %0b",
                                out_mon.stir_start, want.stir_start));
    if (out_mon.stir_speed !== want.stir_speed)
      report_mismatch($sformatf("stir_speed %0d, expected %0d",
                                out_mon.stir_speed, want.stir_speed));
    if (out_mon.foam_alarm !== want.foam_alarm)
      report_mismatch($sformatf("foam_alarm %0b, expected %0b",
                                out_mon.foam_alarm, want.foam_alarm));
    if (out_mon.phase !== want.phase)
      report_mismatch($sformatf("phase %0d, expected %0d", out_mon.phase, want.phase));
    if (out_mon.phase_changed !== want.phase_changed)
      report_mismatch($sformatf("phase_changed %0b, expected %0b",
                                out_mon.phase_changed, want.phase_changed));
    if (out_mon.done_res !== want.done_res)
      report_mismatch($sformatf("done_res %0b, expected %0b",
                                out_mon.done_res, want.done_res));
  endtask

  always @(posedge clk) begin
    in_item_t tick;
    if (!rst_n) begin
      regs                 = '0;
      regs.target_temp     = TARGET_TEMP_RST;
      regs.band_half_width = BAND_HALF_RST;
      cur_phase            = PH_NONE;
      phase_start          = '0;
      valve_stamp          = '0;
      cooling_on           = 1'b0;
      valve_on             = 1'b0;
      pending_q.delete();
    end else begin
      if (cfg_we) write_register(cfg_idx, cfg_wdata);
      if (in_mon.valid && in_mon.ready) begin
        tick = '{now_ms: in_mon.now_ms, temp_valid: in_mon.temp_valid,
                 temp_centi: in_mon.temp_centi, level_mv: in_mon.level_mv};
        pending_q.push_back(thermostat_step(tick));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_q.size() == 0) report_mismatch("result with no tick outstanding");
        else compare_result(pending_q.pop_front());
        result_no++;
      end
    end
    outstanding = pending_q.size();
  end

endmodule

`default_nettype wire

### bench/fermentation_thermostat_unit_tb.sv
// Testbench top for the fermentation thermostat unit: clock, reset, register writes,
// tick stimulus and result back-pressure, with ftu_result_checker beside the block.
// Needs ftu_pkg, ftu_in_if, ftu_out_if, ftu_result_checker and the RTL.
`default_nettype none

module fermentation_thermostat_unit_tb;
  import ftu_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int F_COOL  = 1 << FLAG_COOL;
  localparam int F_HEAT  = 1 << FLAG_HEAT;
  localparam int F_STIR  = 1 << FLAG_STIR;
  localparam int F_LEVEL = 1 << FLAG_LEVEL;
  localparam int F_ABOVE = 1 << FLAG_TRIG_ABOVE;
  localparam int F_ALL   = F_COOL | F_HEAT | F_STIR | F_LEVEL | F_ABOVE;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;

  // stimulus shaping; steady_flow and hold_off_req are shared with the receiver process
  bit          steady_flow  = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          march;
  int          max_step;
  logic [31:0] now_cursor;
  int          tgt, band, en_flags, thr, dur;

  ftu_in_if  in_ch ();
  ftu_out_if out_ch ();

  fermentation_thermostat_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ftu_result_checker thermo_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("** fermentation_thermostat_unit: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // mostly around the hysteresis band, some full-range and exact edges
  function automatic int gen_temp();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 75) v = tgt - band - 150 + int'($urandom_range(0, 2 * band + 300));
    else if (r < 87) v = int'($urandom_range(0, 32767)) - 16384;
    else begin
      case ($urandom_range(0, 5))
        0: v = tgt - band - 1;
        1: v = tgt - band;
        2: v = tgt + band;
        3: v = tgt + band + 1;
        4: v = STIR_SAFE_TEMP;
        default: v = STIR_SAFE_TEMP + 1;
      endcase
    end
    return clamp(v, -16384, 16383);
  endfunction

  // keep foam rare enough that the band logic gets exercised
  function automatic int gen_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return clamp(thr - 4 + int'($urandom_range(0, 8)), 0, 8191);
    if (r < 35) return $urandom_range(0, 8191);
    if (en_flags & F_ABOVE) return (thr > 0) ? $urandom_range(0, thr - 1) : 0;
    return (thr < 8191) ? $urandom_range(thr + 1, 8191) : 8191;
  endfunction

  function automatic logic [31:0] next_time();
    if (!march) now_cursor = $urandom();
    else if ($urandom_range(0, 9) != 0) now_cursor += $urandom_range(1, max_step);
    return now_cursor;
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic tick(input logic [31:0] now, input bit v, input int temp, input int level);
    int g;
    in_ch.valid      <= 1'b1;
    in_ch.now_ms     <= now;
    in_ch.temp_valid <= v;
    in_ch.temp_centi <= 15'(temp);
    in_ch.level_mv   <= 13'(level);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    g = steady_flow ? 0 : pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic random_tick();
    tick(next_time(), $urandom_range(0, 9) != 0, gen_temp(), gen_level());
  endtask

  // registers change only with nothing in flight
  task automatic load_settings(input int t, input int b, input int f, input int th,
                               input int off_s, input int on_s, input int hrs,
                               input int spd);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    tgt = t; band = b; en_flags = f; thr = th; dur = hrs;
    for (int i = 0; i < 8; i++) begin
      cfg_we  <= 1'b1;
      cfg_idx <= CFG_IDX_W'(i);
      case (CFG_IDX_W'(i))
        CFG_TARGET_TEMP:  cfg_wdata <= 16'(t);
        CFG_BAND_HALF:    cfg_wdata <= 16'(b);
        CFG_ENABLE_FLAGS: cfg_wdata <= 16'(f);
        CFG_LEVEL_THR:    cfg_wdata <= 16'(th);
        CFG_MIN_OFF_SEC:  cfg_wdata <= 16'(off_s);
        CFG_MIN_ON_SEC:   cfg_wdata <= 16'(on_s);
        CFG_DURATION_HRS: cfg_wdata <= 16'(hrs);
        default:          cfg_wdata <= 16'(spd);
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, stretches of steady flow, one long hold-off on request
  initial begin : result_sink
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (steady_flow) begin
        out_ch.ready <= 1'b1;
      end else begin
        g = pick_gap();
        out_ch.ready <= (g == 0);
        if (g > 1) repeat (g - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int          wait_cnt;
    logic [31:0] ferm_t0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.now_ms     = '0;
    in_ch.temp_valid = 1'b0;
    in_ch.temp_centi = '0;
    in_ch.level_mv   = '0;
    tgt = 2200; band = 50; en_flags = 0; thr = 0; dur = 0;
    march = 1'b0; max_step = 1000; now_cursor = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, every feature disabled
    tick(32'd0, 1'b0, 0, 0);
    tick(32'd1, 1'b1, -16384, 0);
    tick(32'd2, 1'b1, 16383, 8191);
    tick(32'd3, 1'b1, 2149, 0);       // just below the band
    tick(32'd4, 1'b1, 2150, 0);
    tick(32'd5, 1'b1, 2250, 0);
    tick(32'd6, 1'b1, 2251, 0);       // above the band, but no cooling
    load_settings(2200, 50, F_ALL, 3000, 0, 0, 0, 100);
    tick(32'd100, 1'b1, 2251, 0);     // cooling opens the valve
    tick(32'd101, 1'b1, 2251, 3000);  // foam right at threshold
    tick(32'd102, 1'b1, 6000, 8191);
    tick(32'd103, 1'b1, 6001, 3000);  // too warm for the stirrer
    tick(32'd104, 1'b1, 2200, 2999);  // back in band, valve closes
    tick(32'd105, 1'b1, 2100, 0);     // heating with heater enabled
    tick(32'd106, 1'b0, 2100, 3000);  // invalid reading wins over foam
    load_settings(2200, 50, F_COOL | F_STIR | F_LEVEL, 3000, 0, 0, 0, 100);
    tick(32'hFFFF_FFFF, 1'b1, -16384, 3000);  // foam right at threshold, triggering at or below
    tick(32'd7, 1'b1, 2300, 3001);
    tick(32'd8, 1'b1, 2200, 8191);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          load_settings(2200, 50, F_ALL, 3000, 0, 0, 0, 100);
          march = 1'b0;
        end
        1: begin
          load_settings(-5000, 0, F_COOL | F_HEAT | F_STIR, 0, 65535, 65535, 0, 0);
          march = 1'b1; max_step = 1 << 26;
        end
        2: begin
          // one-hour duration: time steps stay small so the phase never completes
          load_settings(15000, 2000, F_COOL | F_HEAT | F_LEVEL, 6144, 5, 3, 1, 37);
          march = 1'b1; max_step = 3000;
        end
        4: begin
          load_settings(0, 2047, F_ALL, 8191, 1, 1, 0, 127);
          march = 1'b1; max_step = 2500;
        end
        5: begin
          load_settings(2200, 50, F_COOL | F_HEAT, 0, 10, 20, 0, 55);
          march = 1'b1; max_step = 4000;
        end
        default: begin
          load_settings(int'($urandom_range(0, 32767)) - 16384, $urandom_range(0, 2047),
                        $urandom_range(0, 31), $urandom_range(0, 8191),
                        $urandom_range(0, 20), $urandom_range(0, 20), 0,
                        $urandom_range(0, 127));
          march = $urandom_range(0, 1); max_step = 30000;
        end
      endcase
      now_cursor  = $urandom();
      steady_flow = ($urandom_range(0, 3) == 0);
      if (p == 1) begin
        steady_flow  = 1'b1;
        hold_off_req = 1'b1;
      end
      // force a heating tick so a later fermenting phase starts its clock fresh
      if (dur != 0) tick(next_time(), 1'b1, tgt - band - 1, 8191);
      repeat (100) random_tick();
    end

    // completion at a 1000-hour duration, across the time wrap
    steady_flow = 1'b0;
    load_settings(2200, 50, F_HEAT, 0, 0, 0, 1000, 0);
    ferm_t0 = 32'hFFFF_FF10;
    tick(32'hFFFF_FF00, 1'b1, 2000, 0);
    tick(ferm_t0, 1'b1, 2200, 0);
    tick(ferm_t0 + 32'd3599999999, 1'b1, 2200, 0);
    tick(ferm_t0 + 32'd3599999999, 1'b0, 2200, 0);
    tick(ferm_t0 + 32'd3600000000, 1'b1, 2200, 0);
    march = 1'b0;
    repeat (8) random_tick();         // ignored once completed

    in_ch.valid <= 1'b0;
    wait_cnt = 0;
    while (outstanding != 0 && wait_cnt < 2000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** fermentation_thermostat_unit: PASSED **");
    end else begin
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      $display("** fermentation_thermostat_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
